[design/typed_value_scan_filter_assert.svh]
// assertion macros for the scan filter
`ifndef TYPED_VALUE_SCAN_FILTER_ASSERT_SVH
`define TYPED_VALUE_SCAN_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TVSF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TVSF_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TVSF_ASSERT(label, clk, rst_n, prop, msg)
`define TVSF_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[design/tvsf_pkg.sv]
package tvsf_pkg;

  typedef enum logic [2:0] {
    KIND_U8  = 3'd0,
    KIND_S8  = 3'd1,
    KIND_U16 = 3'd2,
    KIND_S16 = 3'd3,
    KIND_U32 = 3'd4,
    KIND_S32 = 3'd5,
    KIND_F32 = 3'd6,
    KIND_RSV = 3'd7
  } value_kind_e;

  typedef enum logic [2:0] {
    MODE_EQ   = 3'd0,
    MODE_NE   = 3'd1,
    MODE_GT   = 3'd2,
    MODE_LT   = 3'd3,
    MODE_CHG  = 3'd4,
    MODE_SAME = 3'd5,
    MODE_INC  = 3'd6,
    MODE_DEC  = 3'd7
  } compare_mode_e;

  typedef enum logic [1:0] {
    REG_VALUE_KIND   = 2'd0,
    REG_COMPARE_MODE = 2'd1,
    REG_TARGET_VALUE = 2'd2,
    REG_ALIGNED_ONLY = 2'd3
  } reg_index_e;

  typedef struct packed {
    logic        first_of_scan;
    logic [31:0] address;
    logic [31:0] current_value;
    logic [31:0] previous_value;
  } cand_t;

  typedef struct packed {
    logic [31:0] match_address;
    logic [31:0] match_previous;
    logic [31:0] match_current;
    logic [15:0] result_index;
    logic        cap_reached;
  } match_t;

endpackage

[design/typed_value_scan_filter.sv]
// typed value scan filter
// path: an accepted candidate goes through the input register, then the result register
// throughput: one candidate per cycle while in_stall_o is low; a skid register holds one result under stall
// reset: asynchronous active low; registers return to u32/equal/target 0/aligned,
//   match count cleared, both pipeline stages empty
`include "typed_value_scan_filter_assert.svh"
module typed_value_scan_filter #(
  parameter int unsigned MAX_RESULTS = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tvsf_pkg::cand_t       in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output tvsf_pkg::match_t      out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_RESULTS + 1);
  localparam logic [CntW-1:0] CapVal = CntW'(MAX_RESULTS);

  // configuration registers
  logic [2:0]  kind_q;
  logic [2:0]  mode_q;
  logic [31:0] target_q;
  logic        aligned_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= tvsf_pkg::KIND_U32;
      mode_q    <= tvsf_pkg::MODE_EQ;
      target_q  <= '0;
      aligned_q <= 1'b1;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      unique case (tvsf_pkg::reg_index_e'(paddr[3:2]))
        tvsf_pkg::REG_VALUE_KIND:   kind_q    <= pwdata[2:0];
        tvsf_pkg::REG_COMPARE_MODE: mode_q    <= pwdata[2:0];
        tvsf_pkg::REG_TARGET_VALUE: target_q  <= pwdata;
        tvsf_pkg::REG_ALIGNED_ONLY: aligned_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    unique case (tvsf_pkg::reg_index_e'(paddr[3:2]))
      tvsf_pkg::REG_VALUE_KIND:   prdata = {29'd0, kind_q};
      tvsf_pkg::REG_COMPARE_MODE: prdata = {29'd0, mode_q};
      tvsf_pkg::REG_TARGET_VALUE: prdata = target_q;
      tvsf_pkg::REG_ALIGNED_ONLY: prdata = {31'd0, aligned_q};
      default: prdata = '0;
    endcase
  end

  // output side: main result register plus skid register
  logic             out_v_q, skid_v_q;
  tvsf_pkg::match_t out_q, skid_q;
  logic             s1_v_q;
  tvsf_pkg::cand_t  s1_q;
  logic             s1_adv;

  // stage 1 advances when the skid slot is free
  assign s1_adv     = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_adv) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  // value decode and compare
  logic [31:0] opa, opb, key_a, key_b, mask, sgn;
  logic        is_f32, is_sgn, misal, nan_any, zero_both, ord_eq, ord_gt, ord_lt, hit;
  logic [1:0]  low_bits;

  always_comb begin
    opa    = s1_q.current_value;
    opb    = (mode_q[2]) ? s1_q.previous_value : target_q;
    is_f32 = (kind_q == tvsf_pkg::KIND_F32);
    is_sgn = 1'b0;
    mask   = 32'hFFFF_FFFF;
    sgn    = 32'h8000_0000;
    low_bits = 2'b00;
    case (tvsf_pkg::value_kind_e'(kind_q))
      tvsf_pkg::KIND_U8, tvsf_pkg::KIND_S8: begin
        mask = 32'h0000_00FF; sgn = 32'h0000_0080; low_bits = 2'b00;
      end
      tvsf_pkg::KIND_U16, tvsf_pkg::KIND_S16: begin
        mask = 32'h0000_FFFF; sgn = 32'h0000_8000; low_bits = 2'b01;
      end
      default: begin
        low_bits = 2'b11;
      end
    endcase
    is_sgn = (kind_q == tvsf_pkg::KIND_S8) || (kind_q == tvsf_pkg::KIND_S16) ||
             (kind_q == tvsf_pkg::KIND_S32);
    misal  = aligned_q && ((s1_q.address[1:0] & low_bits) != 2'b00);

    nan_any   = is_f32 && (((opa[30:23] == 8'hFF) && (opa[22:0] != '0)) ||
                           ((opb[30:23] == 8'hFF) && (opb[22:0] != '0)));
    zero_both = is_f32 && (opa[30:0] == '0) && (opb[30:0] == '0);

    if (is_f32) begin
      key_a = opa[31] ? ~opa : (opa | 32'h8000_0000);
      key_b = opb[31] ? ~opb : (opb | 32'h8000_0000);
    end else begin
      key_a = (opa & mask) ^ (is_sgn ? sgn : 32'd0);
      key_b = (opb & mask) ^ (is_sgn ? sgn : 32'd0);
    end
    ord_eq = zero_both || (key_a == key_b);
    ord_gt = !ord_eq && (key_a > key_b);
    ord_lt = !ord_eq && !ord_gt;

    case (tvsf_pkg::compare_mode_e'(mode_q))
      tvsf_pkg::MODE_EQ, tvsf_pkg::MODE_SAME: hit = ord_eq;
      tvsf_pkg::MODE_NE, tvsf_pkg::MODE_CHG:  hit = !ord_eq;
      tvsf_pkg::MODE_GT, tvsf_pkg::MODE_INC:  hit = ord_gt;
      default:                                hit = ord_lt;
    endcase
    hit = hit && !nan_any && !misal;
  end

  // match counter
  logic [CntW-1:0] cnt_q, cnt_base, cnt_next;
  logic            emit;

  assign cnt_base = s1_q.first_of_scan ? '0 : cnt_q;
  assign emit     = s1_v_q && s1_adv && hit && (cnt_base < CapVal);
  assign cnt_next = cnt_base + CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (s1_v_q && s1_adv) begin
      cnt_q <= emit ? cnt_next : cnt_base;
    end
  end

  tvsf_pkg::match_t res;
  logic [CntW+15:0] base_ext;
  assign base_ext = {16'd0, cnt_base};

  always_comb begin
    res.match_address  = s1_q.address;
    res.match_previous = s1_q.previous_value;
    res.match_current  = s1_q.current_value;
    res.result_index   = base_ext[15:0];
    res.cap_reached    = (cnt_next >= CapVal);
  end

  // result register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (out_v_q && out_stall_i && !skid_v_q) begin
        skid_v_q <= emit;
      end else if (!out_stall_i || !out_v_q) begin
        if (skid_v_q) begin
          out_v_q  <= 1'b1;
          skid_v_q <= 1'b0;
        end else begin
          out_v_q <= emit;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && out_stall_i && !skid_v_q) begin
      skid_q <= res;
    end else if (!out_stall_i || !out_v_q) begin
      out_q <= skid_v_q ? skid_q : res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // checks
  `TVSF_ASSERT(a_skid_needs_out, clk_i, rst_ni, skid_v_q |-> out_v_q,
               "skid full while output empty")
  `TVSF_ASSERT(a_cnt_cap, clk_i, rst_ni, cnt_q <= CapVal, "match count beyond cap")
  `TVSF_ASSERT(a_stall_out_hold, clk_i, rst_ni,
               (out_v_q && out_stall_i) |=> (out_v_q && $stable(out_q)),
               "stalled result changed")
  `TVSF_ASSERT_RST(a_rst_empty, clk_i, !rst_ni |-> (!out_v_q && !skid_v_q),
                   "pipeline not empty in reset")

endmodule
